/* sv/tlpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_pkg
// shared types and constants for the three-level priority queue
// ----------------------------------------------------------------------------
package tlpq_pkg;

    localparam int DEPTH_DEF         = 16;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    localparam int LEVEL_W   = 2;
    localparam int STATUS_W  = 2;
    localparam int IN_PAY_W  = 32;
    localparam int OUT_PAY_W = 32;
    localparam int OCC_W     = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic                OP_INSERT = 1'b0;
    localparam logic                OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 2'd2;

    typedef struct packed {
        logic               shift_in;
        logic               shift_out;
        logic [LEVEL_W-1:0] level;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* sv/tlpq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_cell
// one slot of the sorted chain: holds, takes the new entry or shifts
// ----------------------------------------------------------------------------
module tlpq_cell
    import tlpq_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic [PAYLOAD_WIDTH-1:0] new_payload,
    input  wire logic                     occ,
    input  wire logic                     prev_keep,
    input  wire logic [LEVEL_W-1:0]       prev_level,
    input  wire logic [PAYLOAD_WIDTH-1:0] prev_payload,
    input  wire logic [LEVEL_W-1:0]       next_level,
    input  wire logic [PAYLOAD_WIDTH-1:0] next_payload,
    output logic [LEVEL_W-1:0]            level,
    output logic [PAYLOAD_WIDTH-1:0]      payload,
    output logic                          keep
);

    logic [LEVEL_W-1:0]       level_reg;
    logic [LEVEL_W-1:0]       level_next;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_next;

    assign keep    = occ && (level_reg <= ctrl.level);
    assign level   = level_reg;
    assign payload = payload_reg;

    always_comb
    begin
        level_next   = level_reg;
        payload_next = payload_reg;
        if (ctrl.shift_in && !keep)
        begin
            if (prev_keep)
            begin
                level_next   = ctrl.level;
                payload_next = new_payload;
            end
            else
            begin
                level_next   = prev_level;
                payload_next = prev_payload;
            end
        end
        else if (ctrl.shift_out)
        begin
            level_next   = next_level;
            payload_next = next_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg   <= level_next;
        payload_reg <= payload_next;
    end

endmodule
`default_nettype wire

/* sv/three_level_priority_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_priority_queue
// bounded priority queue with three levels, fifo within a level
// ----------------------------------------------------------------------------
// Each request is an insert (opcode 0) or a remove of the head (opcode 1) and
// gives exactly one response. Entries sit in a chain of DEPTH cells kept in
// queue order; on an insert every cell compares its own level with the new
// one at once and either holds, takes the new entry or takes its left
// neighbour, and on a remove every cell takes its right neighbour. One
// request is thus taken every clock cycle unless an untaken response stalls
// it; the response sits in an output register in the next cycle, and the
// single chain update per cycle sets that rate. Level 3 is treated as level
// 2. An empty remove answers status 1, a full insert is dropped with status 2.
module three_level_priority_queue
    import tlpq_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // opcode[0], level[2:1], payload[34:3], zero pad[39:35]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // status[1:0], out_payload[33:2], out_level[35:34], occupancy[40:36],
    // is_empty[41], zero pad[47:42]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     in_fire;
    logic                     op;
    logic [LEVEL_W-1:0]       lvl_raw;
    logic [LEVEL_W-1:0]       lvl;
    logic [PAYLOAD_WIDTH-1:0] pay;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_next;

    logic [LEVEL_W-1:0]       cell_lvl [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] cell_pay [DEPTH];
    logic [DEPTH-1:0]         cell_keep;
    logic [DEPTH-1:0]         cell_occ;

    logic [STATUS_W-1:0]      status;
    logic [OUT_PAY_W-1:0]     out_payload;
    logic [LEVEL_W-1:0]       out_level;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign op       = s_tdata[0];
    assign lvl_raw  = s_tdata[2:1];
    assign lvl      = (lvl_raw > LEVEL_MAX) ? LEVEL_MAX : lvl_raw;
    assign pay      = PAYLOAD_WIDTH'(s_tdata[3 +: IN_PAY_W]);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.shift_in  = in_fire && (op == OP_INSERT) && !full;
    assign ctrl.shift_out = in_fire && (op == OP_REMOVE) && !empty;
    assign ctrl.level     = lvl;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                     prev_keep;
            logic [LEVEL_W-1:0]       prev_level;
            logic [PAYLOAD_WIDTH-1:0] prev_payload;
            logic [LEVEL_W-1:0]       next_level;
            logic [PAYLOAD_WIDTH-1:0] next_payload;

            assign cell_occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign prev_keep    = 1'b1;
                assign prev_level   = lvl;
                assign prev_payload = pay;
            end
            else
            begin : g_mid
                assign prev_keep    = cell_keep[gi-1];
                assign prev_level   = cell_lvl[gi-1];
                assign prev_payload = cell_pay[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign next_level   = cell_lvl[gi];
                assign next_payload = cell_pay[gi];
            end
            else
            begin : g_inner
                assign next_level   = cell_lvl[gi+1];
                assign next_payload = cell_pay[gi+1];
            end

            tlpq_cell #(
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .new_payload  (pay),
                .occ          (cell_occ[gi]),
                .prev_keep    (prev_keep),
                .prev_level   (prev_level),
                .prev_payload (prev_payload),
                .next_level   (next_level),
                .next_payload (next_payload),
                .level        (cell_lvl[gi]),
                .payload      (cell_pay[gi]),
                .keep         (cell_keep[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status      = STATUS_OK;
        out_payload = '0;
        out_level   = '0;
        if (ctrl.shift_in)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.shift_out)
        begin
            count_next  = count_reg - 1'b1;
            out_payload = OUT_PAY_W'(cell_pay[0]);
            out_level   = cell_lvl[0];
        end
        else if (op == OP_INSERT)
        begin
            status = STATUS_FULL;
        end
        else
        begin
            status = STATUS_EMPTY;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (in_fire)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, (count_next == '0), OCC_W'(count_next),
                             out_level, out_payload, status};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg <= count_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
